FILE: hdl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the affine point transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

  localparam int FracBitsDef   = 16;
  localparam int CoordWidthDef = 32;
  localparam int DataW         = 32;
  localparam int CoefW         = 32;
  localparam int CfgW          = 64;
  localparam int NumRegs       = 6;
  localparam int CfgIdxW       = 3;
  localparam int NumLanes      = 3;

  localparam logic [CfgIdxW-1:0] REG_ROW0_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW0_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW1_FIRST  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW1_SECOND = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW2_FIRST  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROW2_SECOND = 3'd5;

  localparam logic [CfgW-1:0] RST_ROW0_FIRST  = 64'h0001_0000_0000_0000;
  localparam logic [CfgW-1:0] RST_ROW0_SECOND = 64'h0000_0000_0000_0000;
  localparam logic [CfgW-1:0] RST_ROW1_FIRST  = 64'h0000_0000_0001_0000;
  localparam logic [CfgW-1:0] RST_ROW1_SECOND = 64'h0000_0000_0000_0000;
  localparam logic [CfgW-1:0] RST_ROW2_FIRST  = 64'h0000_0000_0000_0000;
  localparam logic [CfgW-1:0] RST_ROW2_SECOND = 64'h0001_0000_0000_0000;

  typedef enum logic [1:0] {
    FUNC_POINT  = 2'd0,
    FUNC_VECTOR = 2'd1,
    FUNC_CONTRA = 2'd2,
    FUNC_PLANAR = 2'd3
  } func_e;

  typedef struct packed {
    logic [CoefW-1:0] c1;
    logic [CoefW-1:0] c2;
    logic [CoefW-1:0] c3;
    logic [CoefW-1:0] t;
  } lane_coef_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

`default_nettype wire

FILE: hdl/apt_lane.sv
// ----------------------------------------------------------------------------
// apt_lane
// One output lane: three products, translation, wide sum, round, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_lane import apt_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk_i,
  input  pipe_en_t                      en_i,
  input  lane_coef_t                    coef_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  output logic signed [DataW-1:0]       res_o,
  output logic                          clip_o
);

  localparam int ProdW  = CoefW + COORD_WIDTH;
  localparam int TransW = CoefW + FRAC_BITS;
  localparam int SumW   = ((ProdW > TransW) ? ProdW : TransW) + 2;
  localparam int UpW    = SumW - COORD_WIDTH + 1;

  localparam logic signed [COORD_WIDTH-1:0] SatMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SatMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [ProdW-1:0] p1_d, p2_d, p3_d;
  logic signed [ProdW-1:0] p1_q, p2_q, p3_q;
  logic signed [SumW-1:0]  tr_d, tr_q;
  logic signed [SumW-1:0]  s01_d, s23_d, s01_q, s23_q;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic signed [SumW-1:0]  shifted;
  logic        [UpW-1:0]   upper;
  logic                    ovf;
  logic signed [DataW-1:0] res_d, res_q;
  logic                    clip_d, clip_q;

  assign p1_d = ProdW'($signed(coef_i.c1)) * ProdW'(x_i);
  assign p2_d = ProdW'($signed(coef_i.c2)) * ProdW'(y_i);
  assign p3_d = ProdW'($signed(coef_i.c3)) * ProdW'(z_i);
  assign tr_d = (SumW'($signed(coef_i.t)) <<< FRAC_BITS)
              + (SumW'(1) <<< (FRAC_BITS - 1));

  assign s01_d = SumW'(p1_q) + SumW'(p2_q);
  assign s23_d = SumW'(p3_q) + tr_q;
  assign sum_d = s01_q + s23_q;

  assign shifted = sum_q >>> FRAC_BITS;
  assign upper   = shifted[SumW-1:COORD_WIDTH-1];
  assign ovf     = !((&upper) || !(|upper));

  always_comb begin
    if (ovf) begin
      res_d = shifted[SumW-1] ? DataW'(SatMin) : DataW'(SatMax);
    end else begin
      res_d = DataW'($signed(shifted[COORD_WIDTH-1:0]));
    end
    clip_d = ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      tr_q <= tr_d;
    end
    if (en_i.s3) begin
      s01_q <= s01_d;
      s23_q <= s23_d;
    end
    if (en_i.s4) begin
      sum_q <= sum_d;
    end
    if (en_i.s5) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

`default_nettype wire

FILE: hdl/affine_point_transform_top.sv
// Throughput: one item per cycle while the output is not stalled;
// five register stages (input and coefficient select, multiply, pair sums,
// final sum, round and saturate).
// A stall on the output halts the full pipeline only when every stage is valid.
// Reset clears all valid bits and loads the identity matrix into the registers.
// ----------------------------------------------------------------------------
// affine_point_transform_top
// Q16.16 3x4 affine transform of one coordinate triple per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_transform_top import apt_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic signed [DataW-1:0] in_x_i,
  input  logic signed [DataW-1:0] in_y_i,
  input  logic signed [DataW-1:0] in_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] out_x_o,
  output logic signed [DataW-1:0] out_y_o,
  output logic signed [DataW-1:0] out_z_o,
  output logic                    clipped_o
);

  logic [CfgW-1:0] cfg_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= RST_ROW0_FIRST;
      cfg_q[1] <= RST_ROW0_SECOND;
      cfg_q[2] <= RST_ROW1_FIRST;
      cfg_q[3] <= RST_ROW1_SECOND;
      cfg_q[4] <= RST_ROW2_FIRST;
      cfg_q[5] <= RST_ROW2_SECOND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW0_FIRST:  cfg_q[0] <= cfg_wdata_i;
        REG_ROW0_SECOND: cfg_q[1] <= cfg_wdata_i;
        REG_ROW1_FIRST:  cfg_q[2] <= cfg_wdata_i;
        REG_ROW1_SECOND: cfg_q[3] <= cfg_wdata_i;
        REG_ROW2_FIRST:  cfg_q[4] <= cfg_wdata_i;
        REG_ROW2_SECOND: cfg_q[5] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CoefW-1:0] mat [NumLanes][NumLanes];
  logic [CoefW-1:0] trn [NumLanes];
  lane_coef_t       coef_d [NumLanes];
  lane_coef_t       coef_q [NumLanes];

  always_comb begin
    for (int r = 0; r < NumLanes; r++) begin
      mat[r][0] = cfg_q[2*r][CfgW-1:CoefW];
      mat[r][1] = cfg_q[2*r][CoefW-1:0];
      mat[r][2] = cfg_q[2*r+1][CfgW-1:CoefW];
      trn[r]    = cfg_q[2*r+1][CoefW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      coef_d[i] = '0;
      case (func_e'(func_i))
        FUNC_POINT: begin
          coef_d[i] = '{c1: mat[i][0], c2: mat[i][1], c3: mat[i][2], t: trn[i]};
        end
        FUNC_VECTOR: begin
          coef_d[i] = '{c1: mat[i][0], c2: mat[i][1], c3: mat[i][2], t: '0};
        end
        FUNC_CONTRA: begin
          coef_d[i] = '{c1: mat[0][i], c2: mat[1][i], c3: mat[2][i], t: '0};
        end
        FUNC_PLANAR: begin
          if (i < 2) begin
            coef_d[i] = '{c1: mat[i][0], c2: mat[i][1], c3: '0, t: trn[i]};
          end
        end
        default: coef_d[i] = '0;
      endcase
    end
  end

  logic [4:0] vld_q, vld_d;
  logic [4:0] en;
  pipe_en_t   lane_en;

  always_comb begin
    en[4] = !vld_q[4] || !out_stall_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < 5; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  logic signed [COORD_WIDTH-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q    <= in_x_i[COORD_WIDTH-1:0];
      y_q    <= in_y_i[COORD_WIDTH-1:0];
      z_q    <= in_z_i[COORD_WIDTH-1:0];
      coef_q <= coef_d;
    end
  end

  assign lane_en = '{s2: en[1], s3: en[2], s4: en[3], s5: en[4]};

  logic signed [DataW-1:0] res [NumLanes];
  logic [NumLanes-1:0]     clip;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    apt_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .coef_i(coef_q[g]),
      .x_i   (x_q),
      .y_i   (y_q),
      .z_i   (z_q),
      .res_o (res[g]),
      .clip_o(clip[g])
    );
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[4];
  assign out_x_o     = res[0];
  assign out_y_o     = res[1];
  assign out_z_o     = res[2];
  assign clipped_o   = |clip;

endmodule

`default_nettype wire

FILE: hdl/apt_checker.sv
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks for the affine point transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_checker import apt_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic signed [DataW-1:0] out_x_o,
  input  logic signed [DataW-1:0] out_y_o,
  input  logic signed [DataW-1:0] out_z_o,
  input  logic                    clipped_o
);

  localparam logic signed [DataW-1:0] SatMax =
    DataW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
  localparam logic signed [DataW-1:0] SatMin =
    DataW'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) &&
      $stable(out_y_o) && $stable(out_z_o) && $stable(clipped_o))
    else $error("stalled result changed");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output drains");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("transfer did not reach output in five cycles");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      out_x_o == SatMax || out_x_o == SatMin || out_y_o == SatMax ||
      out_y_o == SatMin || out_z_o == SatMax || out_z_o == SatMin)
    else $error("clip flag without a saturated lane");

endmodule

bind affine_point_transform_top apt_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_apt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_x_o    (out_x_o),
  .out_y_o    (out_y_o),
  .out_z_o    (out_z_o),
  .clipped_o  (clipped_o)
);

`default_nettype wire
